// ===== src/mvt4_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt4_pkg: shared types for the 4x4 matrix-vector transform
// Item layouts, matrix word and row types, write port bundle, request codes.
// ----------------------------------------------------------------------------
package mvt4_pkg;

    localparam int unsigned DIM      = 4;
    localparam int unsigned ENTRIES  = DIM * DIM;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned INDEX_W  = 4;

    // Request codes carried in req_type
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [DIM-1:0]          row_t;

    typedef struct packed {
        logic                 req_type;
        logic [INDEX_W-1:0]   entry_index;
        logic signed [31:0]   entry_value;
        logic signed [31:0]   vec_x;
        logic signed [31:0]   vec_y;
        logic signed [31:0]   vec_z;
        logic signed [31:0]   vec_w;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]   out_x;
        logic signed [31:0]   out_y;
        logic signed [31:0]   out_z;
        logic signed [31:0]   out_w;
    } out_item_t;

    // Matrix entry write request
    typedef struct packed {
        logic                 en;
        logic [INDEX_W-1:0]   index;
        word_t                value;
    } wr_req_t;

endpackage

// ===== src/matrix_vector_transform_4x4_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_core: 4x4 integer matrix times vector
// Pipeline: two register stages, the lane product registers and then the
// output register; a full output register holds until m_ready takes it.
// Throughput: one item per cycle while m_ready keeps up; four row lanes run
// in parallel and a two-stage pipeline (product registers, output register)
// sets the rate. Write items update the matrix and produce no result.
// Reset: matrix returns to identity and the pipeline empties.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mvt4_pkg::in_item_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output mvt4_pkg::out_item_t     m_data
);
    import mvt4_pkg::*;

    logic       p_valid_reg;
    logic       p_valid_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_item_t  m_data_reg;
    out_item_t  m_data_next;
    logic       out_free;
    logic       accept;
    logic       load_p;
    wr_req_t    wr;
    row_t [3:0] rows;
    row_t       vec;
    word_t      sums [DIM];

    // Handshake: product stage moves whenever it is empty or the output slot frees up
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign load_p   = accept && (s_data.req_type == REQ_XFORM);

    // Route write items to the matrix
    assign wr.en    = accept && (s_data.req_type == REQ_WRITE);
    assign wr.index = s_data.entry_index;
    assign wr.value = s_data.entry_value;

    assign vec = {s_data.vec_w, s_data.vec_z, s_data.vec_y, s_data.vec_x};

    mvt4_matrix u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rows    (rows)
    );

    // One lane per matrix row
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        mvt4_lane u_lane (
            .aclk (aclk),
            .load (load_p),
            .row  (rows[r]),
            .vec  (vec),
            .sum  (sums[r])
        );
    end

    // Advance valid flags through the pipeline
    always_comb begin
        p_valid_next = p_valid_reg;
        m_valid_next = m_valid_reg;
        if (s_ready) begin
            p_valid_next = load_p;
        end
        if (out_free) begin
            m_valid_next = p_valid_reg;
        end
    end

    // Merge lane sums into the result item
    always_comb begin
        m_data_next       = m_data_reg;
        if (out_free && p_valid_reg) begin
            m_data_next.out_x = sums[0];
            m_data_next.out_y = sums[1];
            m_data_next.out_z = sums[2];
            m_data_next.out_w = sums[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold result payload until taken
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/mvt4_matrix.sv =====
// ----------------------------------------------------------------------------
// mvt4_matrix: 4x4 coefficient register file
// Sixteen 32-bit entries, identity after reset, one entry written per cycle,
// every row presented in parallel to its lane.
// ----------------------------------------------------------------------------
module mvt4_matrix (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mvt4_pkg::wr_req_t           wr,
    output mvt4_pkg::row_t [3:0]        rows
);
    import mvt4_pkg::*;

    word_t matrix_reg [ENTRIES];

    // Load identity on reset, otherwise update the addressed entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                matrix_reg[i] <= (i / DIM == i % DIM) ? word_t'(1) : word_t'(0);
            end
        end else if (wr.en) begin
            matrix_reg[wr.index] <= wr.value;
        end
    end

    // Present rows in row-major order
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                rows[r][c] = matrix_reg[r * DIM + c];
            end
        end
    end

endmodule

// ===== src/mvt4_lane.sv =====
// ----------------------------------------------------------------------------
// mvt4_lane: one row dot product
// Four 32x32 multipliers keep the low product word in registers; an adder
// tree then folds them into the wrapped row sum.
// ----------------------------------------------------------------------------
module mvt4_lane (
    input  logic                  aclk,
    input  logic                  load,
    input  mvt4_pkg::row_t        row,
    input  mvt4_pkg::row_t        vec,
    output mvt4_pkg::word_t       sum
);
    import mvt4_pkg::*;

    word_t prod_reg [DIM];
    word_t sum01;
    word_t sum23;

    // Capture the low 32 bits of each product
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int c = 0; c < DIM; c++) begin
                prod_reg[c] <= word_t'(row[c] * vec[c]);
            end
        end
    end

    // Add the products, wrapping to 32 bits
    always_comb begin
        sum01 = word_t'(prod_reg[0] + prod_reg[1]);
        sum23 = word_t'(prod_reg[2] + prod_reg[3]);
        sum   = word_t'(sum01 + sum23);
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for matrix_vector_transform_4x4_core
// Streams matrix entry writes and vector transforms into the core. A
// scoreboard keeps its own copy of the matrix and queues one product for each
// accepted transform. Each result is compared lane by lane, in order. Idle
// patterns on both sides change by phase, and one long receiver hold-off
// backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;
    import mvt4_pkg::*;

    localparam int    CLK_HALF     = 4;
    localparam int    RESET_CYCLES = 12;
    localparam int    PHASE_ITEMS  = 590;
    localparam int    BURST_ITEMS  = 40;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    DRAIN_CYCLES = 10;
    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    REPORT_MAX   = 10;
    localparam word_t WORD_MIN     = 32'sh8000_0000;
    localparam word_t WORD_MAX     = 32'sh7FFF_FFFF;

    // Tracks the matrix and the products still owed by the core
    class xform_scoreboard;
        word_t     coeff [ENTRIES];
        out_item_t pending [$];
        int        errors;
        int        checked;

        function new();
            foreach (coeff[i]) coeff[i] = (i % (DIM + 1) == 0) ? 32'sd1 : 32'sd0;
            errors  = 0;
            checked = 0;
        endfunction

        // Apply a write, or queue the product of a transform
        function void note_request(in_item_t req);
            word_t     vec  [DIM];
            word_t     sums [DIM];
            out_item_t prod;
            if (req.req_type == REQ_WRITE) begin
                coeff[req.entry_index] = req.entry_value;
            end else begin
                vec = '{req.vec_x, req.vec_y, req.vec_z, req.vec_w};
                for (int r = 0; r < DIM; r++) begin
                    sums[r] = '0;
                    // 32-bit context: products and sums wrap
                    for (int c = 0; c < DIM; c++) begin
                        sums[r] = sums[r] + coeff[r * DIM + c] * vec[c];
                    end
                end
                prod.out_x = sums[0];
                prod.out_y = sums[1];
                prod.out_z = sums[2];
                prod.out_w = sums[3];
                pending.push_back(prod);
            end
        endfunction

        // Compare one result against the oldest queued product
        function void check_result(out_item_t got);
            out_item_t want;
            word_t     want_l [DIM];
            word_t     got_l  [DIM];
            string     lane   [DIM];
            lane = '{"out_x", "out_y", "out_z", "out_w"};
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("[%0t] result with nothing expected: %h", $realtime, got);
            end else begin
                want   = pending.pop_front();
                want_l = '{want.out_x, want.out_y, want.out_z, want.out_w};
                got_l  = '{got.out_x, got.out_y, got.out_z, got.out_w};
                checked++;
                for (int i = 0; i < DIM; i++) begin
                    if (got_l[i] !== want_l[i]) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("[%0t] result %0d %s: expected %0d (%h), got %0d (%h)",
                                     $realtime, checked, lane[i], want_l[i], want_l[i],
                                     got_l[i], got_l[i]);
                    end
                end
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    xform_scoreboard sb = new();

    int send_idle   = 13;
    int recv_idle   = 77;
    int stall_token = 0;
    int stall_seen  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int n_writes    = 0;
    int n_xforms    = 0;

    matrix_vector_transform_4x4_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d products outstanding",
                     cycle_count, sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive m_ready, run the long hold-off, check accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_token != stall_seen) begin
                stall_seen <= stall_token;
                stall_left <= HOLD_CYCLES;
                m_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Half corner values, some small ones, the rest fully random
    function automatic word_t pick_word();
        case ($urandom_range(9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5, 6:    return word_t'($urandom_range(200) - 100);
            default: return word_t'($urandom);
        endcase
    endfunction

    // Vector fields carry junk; the core must ignore them
    function automatic in_item_t make_write(logic [INDEX_W-1:0] idx, word_t value);
        in_item_t req;
        req.req_type    = REQ_WRITE;
        req.entry_index = idx;
        req.entry_value = value;
        req.vec_x       = word_t'($urandom);
        req.vec_y       = word_t'($urandom);
        req.vec_z       = word_t'($urandom);
        req.vec_w       = word_t'($urandom);
        return req;
    endfunction

    // Entry fields carry junk; the matrix must stay as it is
    function automatic in_item_t make_xform(word_t x, word_t y, word_t z, word_t w);
        in_item_t req;
        req.req_type    = REQ_XFORM;
        req.entry_index = INDEX_W'($urandom_range(15));
        req.entry_value = word_t'($urandom);
        req.vec_x       = x;
        req.vec_y       = y;
        req.vec_z       = z;
        req.vec_w       = w;
        return req;
    endfunction

    function automatic in_item_t random_request();
        if ($urandom_range(99) < 30)
            return make_write(INDEX_W'($urandom_range(15)), pick_word());
        return make_xform(pick_word(), pick_word(), pick_word(), pick_word());
    endfunction

    // Offer one item and hold it until accepted; call on a rising edge
    task automatic send_item(in_item_t req);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        if (req.req_type == REQ_WRITE) n_writes++;
        else                           n_xforms++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_item(random_request());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity matrix: vectors pass through unchanged, extremes included
        send_item(make_xform(32'sd1, 32'sd2, 32'sd3, 32'sd4));
        send_item(make_xform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        send_item(make_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_item(make_xform(-32'sd1, 32'sd0, 32'sd1, WORD_MIN));

        // Load extreme and small values into first, last and scattered entries
        send_item(make_write(4'd0, WORD_MAX));
        send_item(make_write(4'd5, WORD_MIN));
        send_item(make_write(4'd10, -32'sd1));
        send_item(make_write(4'd15, 32'sd0));
        send_item(make_write(4'd3, 32'sd2));
        send_item(make_write(4'd12, WORD_MIN));
        send_item(make_write(4'd6, -32'sd2));
        send_item(make_write(4'd9, WORD_MAX));

        // Products and sums that overflow 32 bits
        send_item(make_xform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        send_item(make_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_item(make_xform(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_item(make_xform(WORD_MAX, WORD_MIN, 32'sd0, 32'sd1));
        send_item(make_xform(32'sd0, 32'sd0, 32'sd0, 32'sd0));

        // Write immediately followed by a transform that uses it
        send_item(make_write(4'd15, 32'sd7));
        send_item(make_xform(32'sd0, 32'sd0, 32'sd0, 32'sd3));

        // Random mix: slow receiver, then slow sender, then full rate
        send_random(PHASE_ITEMS);
        send_idle <= 77;
        recv_idle <= 13;
        send_random(PHASE_ITEMS);
        send_idle <= 0;
        recv_idle <= 0;

        // Hold off the receiver while transforms keep coming
        stall_token <= stall_token + 1;
        for (int i = 0; i < BURST_ITEMS; i++)
            send_item(make_xform(pick_word(), pick_word(), pick_word(), pick_word()));
        send_random(PHASE_ITEMS);
        s_valid <= 1'b0;

        // Drain outstanding products, then watch for strays
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d entry writes and %0d transforms; %0d products checked",
                 n_writes, n_xforms, sb.checked);
        $display("%0d errors, %0d products outstanding", sb.errors, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
